[src/keyed_blob_store_with_compaction_macros.svh]
// Assertion macros shared by the keyed blob store RTL.
// Each macro expects clk and rst_n in scope of the using module.
`ifndef KEYED_BLOB_STORE_WITH_COMPACTION_MACROS_SVH
`define KEYED_BLOB_STORE_WITH_COMPACTION_MACROS_SVH

// Condition holds at every edge out of reset.
`define KBS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequence holds in the same cycle as the antecedent.
`define KBS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence holds in the cycle after the antecedent.
`define KBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/kbs_pkg.sv]
// Shared codes, field widths and the checksum step for the keyed blob store.
// No dependencies.
`timescale 1ns / 1ps

package kbs_pkg;

    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;
    localparam int OFF_W    = 16;
    localparam int LEN_W    = 17;
    localparam int COUNT_W  = 7;
    localparam int SUM_W    = 32;

    localparam logic [CMD_W-1:0] CMD_PUT    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GET    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_SUM   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_ENTRY  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_ZERO_LEN  = 3'd5;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OFF_W-1:0]    blob_offset;
        logic [LEN_W-1:0]    data_length;
        logic [COUNT_W-1:0]  live_entries;
        logic [LEN_W-1:0]    used_bytes;
    } result_t;

    // sum * 33 + byte, modulo 2^32
    function automatic logic [SUM_W-1:0] sum_step(input logic [SUM_W-1:0] sum,
                                                  input logic [7:0] b);
        return (sum << 5) + sum + {24'd0, b};
    endfunction

endpackage

[src/keyed_blob_store_with_compaction.sv]
// Keyed blob store: slot table and byte store in RAM, driven by one sequencer.
// Depends on kbs_pkg, kbs_ram and the assertion macro header.
//
// Use: commands arrive on the s_ stream, one beat per item (command in tuser,
// put-run end marker in tlast). A put run streams one byte per beat; the run
// ends after blob_length bytes or at tlast, and returns one OK beat. Get,
// remove and clear each return one beat; a put that fails on its first byte
// returns its error and the rest of its run is dropped.
// A byte of an open put run is written to the byte store; the byte that closes
// the run also writes its slot-table entry. The first byte of a run adds a
// slot-table walk. Get and remove walk the table; get then reads the blob back
// one byte at a time through the single byte-store read port. A put that is
// short of space compacts first: one table walk per live blob and one more,
// with each blob that is not yet in place moved down byte by byte.
// Results sit in an output register; the next item is taken while a result
// waits, and the sequencer stalls only when it has a new result and that
// register is still full. Reset empties the table at once through per-slot
// live bits; no clearing pass is needed. Byte store contents are undefined.
`timescale 1ns / 1ps
`include "keyed_blob_store_with_compaction_macros.svh"

module keyed_blob_store_with_compaction
    import kbs_pkg::*;
#(
    parameter int ENTRIES     = 64,
    parameter int STORE_BYTES = 65536,
    parameter int KEY_BYTES   = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // key[63:0], blob_length[80:64], data_byte[88:81], zero
    input  logic [1:0]  s_tuser,   // command[1:0]
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // blob_offset[15:0], data_length[32:16],
                                   // live_entries[39:33], used_bytes[56:40], zero
    output logic [2:0]  m_tuser    // status[2:0]
);

    localparam int KW  = 8 * KEY_BYTES;
    localparam int AW  = $clog2(STORE_BYTES);
    localparam int LW  = $clog2(STORE_BYTES + 1);
    localparam int CW  = (LW > LEN_W) ? LW : LEN_W;
    localparam int IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SW  = $clog2(ENTRIES + 1);
    localparam int RW  = KW + AW + LW + SUM_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_SEND  = 4'd3;
    localparam logic [3:0] S_RECHK = 4'd4;
    localparam logic [3:0] S_CRD   = 4'd5;
    localparam logic [3:0] S_CWR   = 4'd6;
    localparam logic [3:0] S_CUPD  = 4'd7;
    localparam logic [3:0] S_BYTE  = 4'd8;
    localparam logic [3:0] S_GRD   = 4'd9;
    localparam logic [3:0] S_GACC  = 4'd10;
    localparam logic [3:0] S_GCHK  = 4'd11;
    localparam logic [3:0] S_EMIT  = 4'd12;

    // control state
    logic [3:0]         state_reg, state_next;
    logic [ENTRIES-1:0] live_reg, live_next;
    logic [LW-1:0]      nf_reg, nf_next;
    logic [SW-1:0]      cnt_reg, cnt_next;
    logic               run_open_reg, run_open_next;
    logic               skip_reg, skip_next;
    logic               pend_reg, pend_next;
    logic               out_vld_reg, out_vld_next;

    // payload and working registers
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [KW-1:0]       key_reg, key_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [7:0]          byte_reg, byte_next;
    logic                last_reg, last_next;
    logic [ENTRIES-1:0]  moved_reg, moved_next;
    logic                cmp_reg, cmp_next;
    logic [IW-1:0]       run_slot_reg, run_slot_next;
    logic [KW-1:0]       run_key_reg, run_key_next;
    logic [AW-1:0]       run_off_reg, run_off_next;
    logic [LW-1:0]       run_len_reg, run_len_next;
    logic [LW-1:0]       run_cnt_reg, run_cnt_next;
    logic [SUM_W-1:0]    run_sum_reg, run_sum_next;
    logic [SW-1:0]       scan_idx_reg, scan_idx_next;
    logic [IW-1:0]       pend_idx_reg, pend_idx_next;
    logic                hit_reg, hit_next;
    logic [IW-1:0]       hit_idx_reg, hit_idx_next;
    logic [KW-1:0]       hit_key_reg, hit_key_next;
    logic [AW-1:0]       hit_off_reg, hit_off_next;
    logic [LW-1:0]       hit_len_reg, hit_len_next;
    logic [SUM_W-1:0]    hit_sum_reg, hit_sum_next;
    logic                free_reg, free_next;
    logic [IW-1:0]       free_idx_reg, free_idx_next;
    logic [LW-1:0]       cursor_reg, cursor_next;
    logic [LW-1:0]       j_reg, j_next;
    logic [SUM_W-1:0]    acc_reg, acc_next;
    logic [STATUS_W-1:0] st_reg, st_next;
    logic [AW-1:0]       res_off_reg, res_off_next;
    logic [LW-1:0]       res_len_reg, res_len_next;
    result_t             out_reg, out_next;

    // RAM ports
    logic          slot_we;
    logic [IW-1:0] slot_wa, slot_ra;
    logic [RW-1:0] slot_wd, slot_rd;
    logic          byte_we;
    logic [AW-1:0] byte_wa, byte_ra;
    logic [7:0]    byte_wd, byte_rd;

    kbs_ram #(.DEPTH(ENTRIES), .ADDR_W(IW), .DATA_W(RW)) u_slot_ram (
        .clk     (clk),
        .we      (slot_we),
        .wr_addr (slot_wa),
        .wr_data (slot_wd),
        .rd_addr (slot_ra),
        .rd_data (slot_rd)
    );

    kbs_ram #(.DEPTH(STORE_BYTES), .ADDR_W(AW), .DATA_W(8)) u_byte_ram (
        .clk     (clk),
        .we      (byte_we),
        .wr_addr (byte_wa),
        .wr_data (byte_wd),
        .rd_addr (byte_ra),
        .rd_data (byte_rd)
    );

    logic [KW-1:0]    e_key;
    logic [AW-1:0]    e_off;
    logic [LW-1:0]    e_len;
    logic [SUM_W-1:0] e_sum;

    assign e_sum = slot_rd[SUM_W-1:0];
    assign e_len = slot_rd[SUM_W +: LW];
    assign e_off = slot_rd[SUM_W+LW +: AW];
    assign e_key = slot_rd[RW-1 -: KW];

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {7'd0, out_reg.used_bytes, out_reg.live_entries,
                       out_reg.data_length, out_reg.blob_offset};

    always_comb
    begin
        logic          scan_start;
        logic          scan_done;
        logic          last_idx;
        logic [CW-1:0] free_space;
        logic          too_long;
        logic [LW-1:0] cnt1;
        logic [SUM_W-1:0] sum_n;
        logic [IW-1:0] open_idx;

        state_next    = state_reg;
        live_next     = live_reg;
        nf_next       = nf_reg;
        cnt_next      = cnt_reg;
        run_open_next = run_open_reg;
        skip_next     = skip_reg;
        pend_next     = pend_reg;
        out_vld_next  = out_vld_reg && !m_tready;
        cmd_next      = cmd_reg;
        key_next      = key_reg;
        len_next      = len_reg;
        byte_next     = byte_reg;
        last_next     = last_reg;
        moved_next    = moved_reg;
        cmp_next      = cmp_reg;
        run_slot_next = run_slot_reg;
        run_key_next  = run_key_reg;
        run_off_next  = run_off_reg;
        run_len_next  = run_len_reg;
        run_cnt_next  = run_cnt_reg;
        run_sum_next  = run_sum_reg;
        scan_idx_next = scan_idx_reg;
        pend_idx_next = pend_idx_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        hit_key_next  = hit_key_reg;
        hit_off_next  = hit_off_reg;
        hit_len_next  = hit_len_reg;
        hit_sum_next  = hit_sum_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        cursor_next   = cursor_reg;
        j_next        = j_reg;
        acc_next      = acc_reg;
        st_next       = st_reg;
        res_off_next  = res_off_reg;
        res_len_next  = res_len_reg;
        out_next      = out_reg;

        slot_we = 1'b0;
        slot_wa = run_slot_reg;
        slot_wd = {run_key_reg, run_off_reg, run_cnt_reg, run_sum_reg};
        slot_ra = scan_idx_reg[IW-1:0];
        byte_we = 1'b0;
        byte_wa = AW'(LW'(run_off_reg) + run_cnt_reg);
        byte_wd = byte_reg;
        byte_ra = AW'(LW'(hit_off_reg) + j_reg);

        scan_start = 1'b0;
        scan_done  = 1'b0;
        last_idx   = (pend_idx_reg == IW'(ENTRIES - 1));
        free_space = CW'(STORE_BYTES) - CW'(nf_reg);
        too_long   = CW'(len_reg) > free_space;
        cnt1       = run_cnt_reg + LW'(1);
        sum_n      = sum_step(run_sum_reg, byte_reg);
        open_idx   = hit_reg ? hit_idx_reg : free_idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next   = s_tuser;
                    key_next   = s_tdata[KW-1:0];
                    len_next   = s_tdata[80:64];
                    byte_next  = s_tdata[88:81];
                    last_next  = s_tlast;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                res_off_next = '0;
                res_len_next = '0;
                if (cmd_reg != CMD_PUT)
                begin
                    // close any open run at the byte count reached so far
                    if (run_open_reg)
                    begin
                        slot_we       = 1'b1;
                        nf_next       = LW'(run_off_reg) + run_cnt_reg;
                        run_open_next = 1'b0;
                    end
                    skip_next = 1'b0;
                    if (cmd_reg == CMD_CLEAR)
                    begin
                        live_next  = '0;
                        nf_next    = '0;
                        cnt_next   = '0;
                        st_next    = ST_OK;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        cmp_next   = 1'b0;
                        scan_start = 1'b1;
                    end
                end
                else if (skip_reg)
                begin
                    if (last_reg)
                    begin
                        skip_next = 1'b0;
                    end
                    state_next = S_IDLE;
                end
                else if (run_open_reg)
                begin
                    state_next = S_BYTE;
                end
                else if (len_reg == '0)
                begin
                    st_next    = ST_ZERO_LEN;
                    skip_next  = !last_reg;
                    state_next = S_EMIT;
                end
                else if (too_long)
                begin
                    cmp_next    = 1'b1;
                    cursor_next = '0;
                    moved_next  = '0;
                    scan_start  = 1'b1;
                end
                else
                begin
                    cmp_next   = 1'b0;
                    scan_start = 1'b1;
                end
            end
            S_SCAN:
            begin
                if (scan_idx_reg < SW'(ENTRIES))
                begin
                    scan_idx_next = scan_idx_reg + SW'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = scan_idx_reg[IW-1:0];
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    if (cmp_reg)
                    begin
                        // lowest offset among live, non-empty, unmoved blobs
                        if (live_reg[pend_idx_reg] && e_len != '0 &&
                            !moved_reg[pend_idx_reg] && (!hit_reg || e_off < hit_off_reg))
                        begin
                            hit_next     = 1'b1;
                            hit_idx_next = pend_idx_reg;
                            hit_key_next = e_key;
                            hit_off_next = e_off;
                            hit_len_next = e_len;
                            hit_sum_next = e_sum;
                        end
                        scan_done = last_idx;
                    end
                    else
                    begin
                        if (!live_reg[pend_idx_reg] && !free_reg)
                        begin
                            free_next     = 1'b1;
                            free_idx_next = pend_idx_reg;
                        end
                        if (live_reg[pend_idx_reg] && e_key == key_reg)
                        begin
                            hit_next     = 1'b1;
                            hit_idx_next = pend_idx_reg;
                            hit_off_next = e_off;
                            hit_len_next = e_len;
                            hit_sum_next = e_sum;
                            scan_done    = 1'b1;
                        end
                        else
                        begin
                            scan_done = last_idx;
                        end
                    end
                end
                if (scan_done)
                begin
                    pend_next  = 1'b0;
                    state_next = S_SEND;
                end
            end
            S_SEND:
            begin
                if (cmp_reg)
                begin
                    if (!hit_reg)
                    begin
                        nf_next    = cursor_reg;
                        state_next = S_RECHK;
                    end
                    else
                    begin
                        moved_next[hit_idx_reg] = 1'b1;
                        j_next = '0;
                        if (LW'(hit_off_reg) != cursor_reg)
                        begin
                            state_next = S_CRD;
                        end
                        else
                        begin
                            cursor_next = cursor_reg + hit_len_reg;
                            scan_start  = 1'b1;
                        end
                    end
                end
                else
                begin
                    case (cmd_reg)
                        CMD_PUT:
                        begin
                            if (!hit_reg && !free_reg)
                            begin
                                st_next    = ST_NO_ENTRY;
                                skip_next  = !last_reg;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                if (!hit_reg)
                                begin
                                    cnt_next = cnt_reg + SW'(1);
                                end
                                live_next[open_idx] = 1'b1;
                                run_slot_next = open_idx;
                                run_key_next  = key_reg;
                                run_off_next  = AW'(nf_reg);
                                run_len_next  = LW'(len_reg);
                                run_cnt_next  = '0;
                                run_sum_next  = '0;
                                run_open_next = 1'b1;
                                nf_next       = nf_reg + LW'(len_reg);
                                state_next    = S_BYTE;
                            end
                        end
                        CMD_GET:
                        begin
                            if (!hit_reg)
                            begin
                                st_next    = ST_NOT_FOUND;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                j_next     = '0;
                                acc_next   = '0;
                                state_next = S_GRD;
                            end
                        end
                        default:
                        begin
                            if (!hit_reg)
                            begin
                                st_next = ST_NOT_FOUND;
                            end
                            else
                            begin
                                live_next[hit_idx_reg] = 1'b0;
                                cnt_next = cnt_reg - SW'(1);
                                st_next  = ST_OK;
                            end
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_RECHK:
            begin
                if (too_long)
                begin
                    st_next    = ST_FULL;
                    skip_next  = !last_reg;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmp_next   = 1'b0;
                    scan_start = 1'b1;
                end
            end
            S_CRD:
            begin
                // read one byte of the blob being moved down
                if (j_reg < hit_len_reg)
                begin
                    state_next = S_CWR;
                end
                else
                begin
                    state_next = S_CUPD;
                end
            end
            S_CWR:
            begin
                byte_we    = 1'b1;
                byte_wa    = AW'(cursor_reg + j_reg);
                byte_wd    = byte_rd;
                j_next     = j_reg + LW'(1);
                state_next = S_CRD;
            end
            S_CUPD:
            begin
                slot_we     = 1'b1;
                slot_wa     = hit_idx_reg;
                slot_wd     = {hit_key_reg, AW'(cursor_reg), hit_len_reg, hit_sum_reg};
                cursor_next = cursor_reg + hit_len_reg;
                scan_start  = 1'b1;
            end
            S_BYTE:
            begin
                byte_we = 1'b1;
                if (last_reg || cnt1 >= run_len_reg)
                begin
                    slot_we       = 1'b1;
                    slot_wd       = {run_key_reg, run_off_reg, cnt1, sum_n};
                    nf_next       = LW'(run_off_reg) + cnt1;
                    run_open_next = 1'b0;
                    st_next       = ST_OK;
                    state_next    = S_EMIT;
                end
                else
                begin
                    run_cnt_next = cnt1;
                    run_sum_next = sum_n;
                    state_next   = S_IDLE;
                end
            end
            S_GRD:
            begin
                if (j_reg < hit_len_reg)
                begin
                    state_next = S_GACC;
                end
                else
                begin
                    state_next = S_GCHK;
                end
            end
            S_GACC:
            begin
                acc_next   = sum_step(acc_reg, byte_rd);
                j_next     = j_reg + LW'(1);
                state_next = S_GRD;
            end
            S_GCHK:
            begin
                if (acc_reg == hit_sum_reg)
                begin
                    st_next      = ST_OK;
                    res_off_next = hit_off_reg;
                    res_len_next = hit_len_reg;
                end
                else
                begin
                    st_next = ST_BAD_SUM;
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // hold until the output register is free
                if (!out_vld_reg || m_tready)
                begin
                    out_next.status       = st_reg;
                    out_next.blob_offset  = OFF_W'(res_off_reg);
                    out_next.data_length  = LEN_W'(res_len_reg);
                    out_next.live_entries = COUNT_W'(cnt_reg);
                    out_next.used_bytes   = LEN_W'(nf_reg);
                    out_vld_next          = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (scan_start)
        begin
            scan_idx_next = '0;
            pend_next     = 1'b0;
            hit_next      = 1'b0;
            free_next     = 1'b0;
            state_next    = S_SCAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            live_reg     <= '0;
            nf_reg       <= '0;
            cnt_reg      <= '0;
            run_open_reg <= 1'b0;
            skip_reg     <= 1'b0;
            pend_reg     <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            live_reg     <= live_next;
            nf_reg       <= nf_next;
            cnt_reg      <= cnt_next;
            run_open_reg <= run_open_next;
            skip_reg     <= skip_next;
            pend_reg     <= pend_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        len_reg      <= len_next;
        byte_reg     <= byte_next;
        last_reg     <= last_next;
        moved_reg    <= moved_next;
        cmp_reg      <= cmp_next;
        run_slot_reg <= run_slot_next;
        run_key_reg  <= run_key_next;
        run_off_reg  <= run_off_next;
        run_len_reg  <= run_len_next;
        run_cnt_reg  <= run_cnt_next;
        run_sum_reg  <= run_sum_next;
        scan_idx_reg <= scan_idx_next;
        pend_idx_reg <= pend_idx_next;
        hit_reg      <= hit_next;
        hit_idx_reg  <= hit_idx_next;
        hit_key_reg  <= hit_key_next;
        hit_off_reg  <= hit_off_next;
        hit_len_reg  <= hit_len_next;
        hit_sum_reg  <= hit_sum_next;
        free_reg     <= free_next;
        free_idx_reg <= free_idx_next;
        cursor_reg   <= cursor_next;
        j_reg        <= j_next;
        acc_reg      <= acc_next;
        st_reg       <= st_next;
        res_off_reg  <= res_off_next;
        res_len_reg  <= res_len_next;
        out_reg      <= out_next;
    end

    `KBS_ASSERT_ALWAYS(a_count_matches_live, $countones(live_reg) == int'(cnt_reg), "live count out of step with live bits")
    `KBS_ASSERT_ALWAYS(a_free_in_range, nf_reg <= LW'(STORE_BYTES), "allocation pointer past end of store")
    `KBS_ASSERT_IMPL(a_run_below_len, run_open_reg, run_cnt_reg < run_len_reg, "open run reached its length")
    `KBS_ASSERT_IMPL(a_ready_only_idle, s_tready, state_reg == S_IDLE && !pend_reg, "ready outside idle")
    `KBS_ASSERT_NEXT(a_emit_loads, state_reg == S_EMIT && (!out_vld_reg || m_tready), m_tvalid && state_reg == S_IDLE, "result not loaded")

endmodule

[src/kbs_ram.sv]
// Single-port-write, single-port-read synchronous RAM with registered read data.
// Used for both the slot table and the byte store; no package dependencies.
`timescale 1ns / 1ps

module kbs_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
